// ===== rtl/rule_line_syntax_checker_unit_defines.svh =====
// assertion helpers shared by the rule line checker
`ifndef RULE_LINE_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define RULE_LINE_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// checked only while out of reset
`define RLSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RLSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rlsc_pkg.sv =====
`default_nettype none
package rlsc_pkg;

  // input commands
  localparam logic [1:0] CMD_CHAR     = 2'd0;
  localparam logic [1:0] CMD_EOL      = 2'd1;
  localparam logic [1:0] CMD_NEW_FILE = 2'd2;

  // error codes, first one found on a line wins
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_STATE_EMPTY   = 4'd1;
  localparam logic [3:0] ERR_STATE_SPACE   = 4'd2;
  localparam logic [3:0] ERR_STATE_COMMA   = 4'd3;
  localparam logic [3:0] ERR_SYM_EMPTY     = 4'd4;
  localparam logic [3:0] ERR_SYM_ARROW     = 4'd5;
  localparam logic [3:0] ERR_SYM_BEFORE    = 4'd6;
  localparam logic [3:0] ERR_SYM_AFTER     = 4'd7;
  localparam logic [3:0] ERR_SYM_COMMA     = 4'd8;
  localparam logic [3:0] ERR_DIR_BAD       = 4'd9;
  localparam logic [3:0] ERR_DIR_COMMA     = 4'd10;
  localparam logic [3:0] ERR_NEXT_BAD      = 4'd11;

  // characters of interest
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_N     = 8'h4E;

  localparam int unsigned OUT_LINE_BITS = 16;

  typedef enum logic [3:0] {
    PH_STATE  = 4'b0001,
    PH_SYMBOL = 4'b0010,
    PH_DIR    = 4'b0100,
    PH_NEXT   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    AR_PRE  = 3'b001,
    AR_DASH = 3'b010,
    AR_POST = 3'b100
  } arrow_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic [3:0]               error_code;
    logic [OUT_LINE_BITS-1:0] line_number;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/rule_line_syntax_checker_unit.sv =====
// Rule line syntax checker: checks text lines of the form state,a->b,dir,next.
// Input channel (in_valid/in_ready/in_data): one command per transfer, either a
// character, an end of line or a start of new file. Result channel
// (out_valid/out_ready/out_data): one result per non-empty line, carrying the
// first error code on the line (0 if clean) and its line number within the file.
// Empty lines only advance the line number. A new file drops any partial line
// and restarts the line count.
// The line state updates at the input transfer and a result sits in the output
// register from the next cycle; one command is taken every cycle while results
// drain.
// A stalled receiver holds the output register; the input then waits until the
// pending result is taken (in_ready follows out_ready in that cycle).
// Synchronous reset clears the line state, the line counter and the output
// register's valid flag; no result is pending after reset.
`default_nettype none
module rule_line_syntax_checker_unit #(
  parameter int unsigned LINE_NUMBER_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rlsc_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rlsc_pkg::out_t     out_data
);

  `include "rule_line_syntax_checker_unit_defines.svh"

  localparam int unsigned EXT_BITS = LINE_NUMBER_BITS + rlsc_pkg::OUT_LINE_BITS;

  rlsc_pkg::phase_t            phase_r, phase_nxt;
  rlsc_pkg::arrow_t            arrow_r, arrow_nxt;
  logic [1:0]                  field_cnt_r, field_cnt_nxt;
  logic [1:0]                  before_cnt_r, before_cnt_nxt;
  logic [1:0]                  after_cnt_r, after_cnt_nxt;
  logic                        line_nonempty_r, line_nonempty_nxt;
  logic                        soc_seen_r, soc_seen_nxt;
  logic                        bad_arrow_r, bad_arrow_nxt;
  logic                        dir_bad_r, dir_bad_nxt;
  logic [3:0]                  first_err_r, first_err_nxt;
  logic [LINE_NUMBER_BITS-1:0] line_cnt_r, line_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rlsc_pkg::out_t              out_data_r, out_data_nxt;

  logic                        in_fire;
  logic [7:0]                  ch;
  logic [3:0]                  sym_err;
  logic [3:0]                  end_err;
  logic [EXT_BITS-1:0]         line_ext;

  function automatic logic [1:0] sat2(input logic [1:0] v);
    sat2 = (v >= 2'd2) ? 2'd2 : v + 2'd1;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign ch       = in_data.char_code;

  // error of the symbol field as it stands
  always_comb begin
    if (field_cnt_r == 2'd0) begin
      sym_err = rlsc_pkg::ERR_SYM_EMPTY;
    end else if (arrow_r != rlsc_pkg::AR_POST || bad_arrow_r) begin
      sym_err = rlsc_pkg::ERR_SYM_ARROW;
    end else if (before_cnt_r > 2'd1) begin
      sym_err = rlsc_pkg::ERR_SYM_BEFORE;
    end else if (after_cnt_r > 2'd1) begin
      sym_err = rlsc_pkg::ERR_SYM_AFTER;
    end else begin
      sym_err = rlsc_pkg::ERR_NONE;
    end
  end

  // error reported if the line ended now
  always_comb begin
    end_err = rlsc_pkg::ERR_NONE;
    if (first_err_r != rlsc_pkg::ERR_NONE) begin
      end_err = first_err_r;
    end else begin
      case (phase_r)
        rlsc_pkg::PH_STATE: begin
          if (field_cnt_r == 2'd0) end_err = rlsc_pkg::ERR_STATE_EMPTY;
          else if (soc_seen_r)     end_err = rlsc_pkg::ERR_STATE_SPACE;
          else                     end_err = rlsc_pkg::ERR_STATE_COMMA;
        end
        rlsc_pkg::PH_SYMBOL: begin
          if (field_cnt_r == 2'd0)                 end_err = rlsc_pkg::ERR_STATE_COMMA;
          else if (sym_err != rlsc_pkg::ERR_NONE) end_err = sym_err;
          else                                     end_err = rlsc_pkg::ERR_SYM_COMMA;
        end
        rlsc_pkg::PH_DIR: begin
          if (field_cnt_r == 2'd0)                     end_err = rlsc_pkg::ERR_SYM_COMMA;
          else if (field_cnt_r > 2'd1 || dir_bad_r)    end_err = rlsc_pkg::ERR_DIR_BAD;
          else                                         end_err = rlsc_pkg::ERR_DIR_COMMA;
        end
        rlsc_pkg::PH_NEXT: begin
          end_err = soc_seen_r ? rlsc_pkg::ERR_NEXT_BAD : rlsc_pkg::ERR_NONE;
        end
        default: begin
          end_err = rlsc_pkg::ERR_NONE;
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    arrow_nxt         = arrow_r;
    field_cnt_nxt     = field_cnt_r;
    before_cnt_nxt    = before_cnt_r;
    after_cnt_nxt     = after_cnt_r;
    line_nonempty_nxt = line_nonempty_r;
    soc_seen_nxt      = soc_seen_r;
    bad_arrow_nxt     = bad_arrow_r;
    dir_bad_nxt       = dir_bad_r;
    first_err_nxt     = first_err_r;
    line_cnt_nxt      = line_cnt_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_data_nxt      = out_data_r;
    line_ext          = {{rlsc_pkg::OUT_LINE_BITS{1'b0}}, line_cnt_r};

    if (in_fire) begin
      case (in_data.cmd)
        rlsc_pkg::CMD_CHAR: begin
          line_nonempty_nxt = 1'b1;
          if (first_err_r == rlsc_pkg::ERR_NONE) begin
            case (phase_r)
              rlsc_pkg::PH_STATE: begin
                if (ch == rlsc_pkg::CH_COMMA) begin
                  if (field_cnt_r == 2'd0) begin
                    first_err_nxt = rlsc_pkg::ERR_STATE_EMPTY;
                  end else if (soc_seen_r) begin
                    first_err_nxt = rlsc_pkg::ERR_STATE_SPACE;
                  end else begin
                    phase_nxt      = rlsc_pkg::PH_SYMBOL;
                    field_cnt_nxt  = 2'd0;
                    soc_seen_nxt   = 1'b0;
                    arrow_nxt      = rlsc_pkg::AR_PRE;
                    before_cnt_nxt = 2'd0;
                    after_cnt_nxt  = 2'd0;
                    bad_arrow_nxt  = 1'b0;
                    dir_bad_nxt    = 1'b0;
                  end
                end else begin
                  field_cnt_nxt = sat2(field_cnt_r);
                  if (ch == rlsc_pkg::CH_SPACE) soc_seen_nxt = 1'b1;
                end
              end
              rlsc_pkg::PH_SYMBOL: begin
                if (ch == rlsc_pkg::CH_COMMA) begin
                  first_err_nxt = sym_err;
                  if (sym_err == rlsc_pkg::ERR_NONE) begin
                    phase_nxt      = rlsc_pkg::PH_DIR;
                    field_cnt_nxt  = 2'd0;
                    soc_seen_nxt   = 1'b0;
                    arrow_nxt      = rlsc_pkg::AR_PRE;
                    before_cnt_nxt = 2'd0;
                    after_cnt_nxt  = 2'd0;
                    bad_arrow_nxt  = 1'b0;
                    dir_bad_nxt    = 1'b0;
                  end
                end else begin
                  field_cnt_nxt = sat2(field_cnt_r);
                  case (arrow_r)
                    rlsc_pkg::AR_PRE: begin
                      if (ch == rlsc_pkg::CH_DASH) arrow_nxt = rlsc_pkg::AR_DASH;
                      else before_cnt_nxt = sat2(before_cnt_r);
                    end
                    rlsc_pkg::AR_DASH: begin
                      if (ch != rlsc_pkg::CH_GT) bad_arrow_nxt = 1'b1;
                      arrow_nxt = rlsc_pkg::AR_POST;
                    end
                    default: begin
                      after_cnt_nxt = sat2(after_cnt_r);
                    end
                  endcase
                end
              end
              rlsc_pkg::PH_DIR: begin
                if (ch == rlsc_pkg::CH_COMMA) begin
                  if (field_cnt_r > 2'd1 || dir_bad_r) begin
                    first_err_nxt = rlsc_pkg::ERR_DIR_BAD;
                  end else begin
                    phase_nxt      = rlsc_pkg::PH_NEXT;
                    field_cnt_nxt  = 2'd0;
                    soc_seen_nxt   = 1'b0;
                    arrow_nxt      = rlsc_pkg::AR_PRE;
                    before_cnt_nxt = 2'd0;
                    after_cnt_nxt  = 2'd0;
                    bad_arrow_nxt  = 1'b0;
                    dir_bad_nxt    = 1'b0;
                  end
                end else begin
                  field_cnt_nxt = sat2(field_cnt_r);
                  if (!(ch inside {rlsc_pkg::CH_L, rlsc_pkg::CH_R, rlsc_pkg::CH_N})) begin
                    dir_bad_nxt = 1'b1;
                  end
                end
              end
              default: begin
                if (ch == rlsc_pkg::CH_SPACE || ch == rlsc_pkg::CH_COMMA) soc_seen_nxt = 1'b1;
              end
            endcase
          end
        end
        rlsc_pkg::CMD_EOL: begin
          if (line_cnt_r != {LINE_NUMBER_BITS{1'b1}}) begin
            line_cnt_nxt = line_cnt_r + {{(LINE_NUMBER_BITS-1){1'b0}}, 1'b1};
          end
          line_ext = {{rlsc_pkg::OUT_LINE_BITS{1'b0}}, line_cnt_nxt};
          if (line_nonempty_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.error_code  = end_err;
            out_data_nxt.line_number = line_ext[rlsc_pkg::OUT_LINE_BITS-1:0];
          end
          phase_nxt         = rlsc_pkg::PH_STATE;
          line_nonempty_nxt = 1'b0;
          first_err_nxt     = rlsc_pkg::ERR_NONE;
          field_cnt_nxt     = 2'd0;
          soc_seen_nxt      = 1'b0;
          arrow_nxt         = rlsc_pkg::AR_PRE;
          before_cnt_nxt    = 2'd0;
          after_cnt_nxt     = 2'd0;
          bad_arrow_nxt     = 1'b0;
          dir_bad_nxt       = 1'b0;
        end
        rlsc_pkg::CMD_NEW_FILE: begin
          // partial line is dropped without a result
          line_cnt_nxt      = '0;
          phase_nxt         = rlsc_pkg::PH_STATE;
          line_nonempty_nxt = 1'b0;
          first_err_nxt     = rlsc_pkg::ERR_NONE;
          field_cnt_nxt     = 2'd0;
          soc_seen_nxt      = 1'b0;
          arrow_nxt         = rlsc_pkg::AR_PRE;
          before_cnt_nxt    = 2'd0;
          after_cnt_nxt     = 2'd0;
          bad_arrow_nxt     = 1'b0;
          dir_bad_nxt       = 1'b0;
        end
        default: begin
          // unused command, nothing changes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= rlsc_pkg::PH_STATE;
      arrow_r         <= rlsc_pkg::AR_PRE;
      field_cnt_r     <= 2'd0;
      before_cnt_r    <= 2'd0;
      after_cnt_r     <= 2'd0;
      line_nonempty_r <= 1'b0;
      soc_seen_r      <= 1'b0;
      bad_arrow_r     <= 1'b0;
      dir_bad_r       <= 1'b0;
      first_err_r     <= rlsc_pkg::ERR_NONE;
      line_cnt_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      arrow_r         <= arrow_nxt;
      field_cnt_r     <= field_cnt_nxt;
      before_cnt_r    <= before_cnt_nxt;
      after_cnt_r     <= after_cnt_nxt;
      line_nonempty_r <= line_nonempty_nxt;
      soc_seen_r      <= soc_seen_nxt;
      bad_arrow_r     <= bad_arrow_nxt;
      dir_bad_r       <= dir_bad_nxt;
      first_err_r     <= first_err_nxt;
      line_cnt_r      <= line_cnt_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RLSC_ASSERT(a_eol_gives_result, in_fire && in_data.cmd == rlsc_pkg::CMD_EOL && line_nonempty_r |=> out_valid_r, "end of a non-empty line gave no result")
  `RLSC_ASSERT(a_line_number_nonzero, out_valid_r |-> out_data_r.line_number != '0, "result with line number zero")
  `RLSC_ASSERT(a_error_needs_text, first_err_r != rlsc_pkg::ERR_NONE |-> line_nonempty_r, "error latched on an empty line")
  `RLSC_ASSERT(a_new_file_clears, in_fire && in_data.cmd == rlsc_pkg::CMD_NEW_FILE |=> line_cnt_r == '0 && !line_nonempty_r, "new file did not restart the line")
  `RLSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result pending after reset")

endmodule
`default_nettype wire

// ===== tb/rule_line_syntax_checker_unit_tb.sv =====
`timescale 1ns / 100ps

module rule_line_syntax_checker_unit_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1000;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  rlsc_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rlsc_pkg::out_t out_data;

  rule_line_syntax_checker_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  rlsc_pkg::in_t  text_stream[$];
  rlsc_pkg::out_t awaited_reports[$];
  rlsc_pkg::out_t oldest_report;
  int   taken = 0;
  int   total_items = 0;
  int   bound1 = 0;
  int   bound2 = 0;
  int   mismatches = 0;

  // line checker state, mirrors the block
  rlsc_pkg::phase_t                   ph;
  rlsc_pkg::arrow_t                   ar;
  logic [1:0]                         field_len;
  logic [1:0]                         pre_len;
  logic [1:0]                         post_len;
  logic                               nonempty;
  logic                               stray_seen;
  logic                               arrow_broken;
  logic                               dir_bad;
  logic [3:0]                         verdict;
  logic [rlsc_pkg::OUT_LINE_BITS-1:0] line_no;

  function automatic logic [1:0] bump(input logic [1:0] v);
    return (v < 2'd2) ? v + 2'd1 : 2'd2;
  endfunction

  function void reset_field();
    field_len    = '0;
    stray_seen   = 1'b0;
    ar           = rlsc_pkg::AR_PRE;
    pre_len      = '0;
    post_len     = '0;
    arrow_broken = 1'b0;
    dir_bad      = 1'b0;
  endfunction

  function void reset_line();
    ph       = rlsc_pkg::PH_STATE;
    nonempty = 1'b0;
    verdict  = rlsc_pkg::ERR_NONE;
    reset_field();
  endfunction

  function logic [3:0] symbol_fault();
    if (field_len == 0) return rlsc_pkg::ERR_SYM_EMPTY;
    if (ar != rlsc_pkg::AR_POST || arrow_broken) return rlsc_pkg::ERR_SYM_ARROW;
    if (pre_len > 1) return rlsc_pkg::ERR_SYM_BEFORE;
    if (post_len > 1) return rlsc_pkg::ERR_SYM_AFTER;
    return rlsc_pkg::ERR_NONE;
  endfunction

  function void absorb_char(input logic [7:0] c);
    nonempty = 1'b1;
    if (verdict != rlsc_pkg::ERR_NONE) return;
    case (ph)
      rlsc_pkg::PH_STATE: begin
        if (c == rlsc_pkg::CH_COMMA) begin
          if (field_len == 0) verdict = rlsc_pkg::ERR_STATE_EMPTY;
          else if (stray_seen) verdict = rlsc_pkg::ERR_STATE_SPACE;
          else begin
            ph = rlsc_pkg::PH_SYMBOL;
            reset_field();
          end
        end else begin
          field_len = bump(field_len);
          if (c == rlsc_pkg::CH_SPACE) stray_seen = 1'b1;
        end
      end
      rlsc_pkg::PH_SYMBOL: begin
        if (c == rlsc_pkg::CH_COMMA) begin
          verdict = symbol_fault();
          if (verdict == rlsc_pkg::ERR_NONE) begin
            ph = rlsc_pkg::PH_DIR;
            reset_field();
          end
        end else begin
          field_len = bump(field_len);
          if (ar == rlsc_pkg::AR_PRE) begin
            if (c == rlsc_pkg::CH_DASH) ar = rlsc_pkg::AR_DASH;
            else pre_len = bump(pre_len);
          end else if (ar == rlsc_pkg::AR_DASH) begin
            if (c != rlsc_pkg::CH_GT) arrow_broken = 1'b1;
            ar = rlsc_pkg::AR_POST;
          end else begin
            post_len = bump(post_len);
          end
        end
      end
      rlsc_pkg::PH_DIR: begin
        if (c == rlsc_pkg::CH_COMMA) begin
          if (field_len > 1 || dir_bad) verdict = rlsc_pkg::ERR_DIR_BAD;
          else begin
            ph = rlsc_pkg::PH_NEXT;
            reset_field();
          end
        end else begin
          field_len = bump(field_len);
          if (c != rlsc_pkg::CH_L && c != rlsc_pkg::CH_R && c != rlsc_pkg::CH_N)
            dir_bad = 1'b1;
        end
      end
      default: begin
        if (c == rlsc_pkg::CH_SPACE || c == rlsc_pkg::CH_COMMA) stray_seen = 1'b1;
      end
    endcase
  endfunction

  function logic [3:0] closing_verdict();
    logic [3:0] e;
    if (verdict != rlsc_pkg::ERR_NONE) return verdict;
    case (ph)
      rlsc_pkg::PH_STATE: begin
        if (field_len == 0) return rlsc_pkg::ERR_STATE_EMPTY;
        if (stray_seen) return rlsc_pkg::ERR_STATE_SPACE;
        return rlsc_pkg::ERR_STATE_COMMA;
      end
      rlsc_pkg::PH_SYMBOL: begin
        if (field_len == 0) return rlsc_pkg::ERR_STATE_COMMA;
        e = symbol_fault();
        return (e != rlsc_pkg::ERR_NONE) ? e : rlsc_pkg::ERR_SYM_COMMA;
      end
      rlsc_pkg::PH_DIR: begin
        if (field_len == 0) return rlsc_pkg::ERR_SYM_COMMA;
        if (field_len > 1 || dir_bad) return rlsc_pkg::ERR_DIR_BAD;
        return rlsc_pkg::ERR_DIR_COMMA;
      end
      default: return stray_seen ? rlsc_pkg::ERR_NEXT_BAD : rlsc_pkg::ERR_NONE;
    endcase
  endfunction

  function void track_command(input rlsc_pkg::in_t it);
    rlsc_pkg::out_t report;
    case (it.cmd)
      rlsc_pkg::CMD_CHAR: absorb_char(it.char_code);
      rlsc_pkg::CMD_EOL: begin
        if (line_no != '1) line_no = line_no + 1'b1;
        if (nonempty) begin
          report.error_code  = closing_verdict();
          report.line_number = line_no;
          awaited_reports.push_back(report);
        end
        reset_line();
      end
      rlsc_pkg::CMD_NEW_FILE: begin
        reset_line();
        line_no = '0;
      end
      default: ;
    endcase
  endfunction

  // stimulus helpers
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == rlsc_pkg::CH_COMMA || c == rlsc_pkg::CH_SPACE || c == rlsc_pkg::CH_DASH)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_dir();
    case ($urandom_range(0, 2))
      0: return rlsc_pkg::CH_L;
      1: return rlsc_pkg::CH_R;
      default: return rlsc_pkg::CH_N;
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c);
    text_stream.push_back(rlsc_pkg::in_t'{cmd: rlsc_pkg::CMD_CHAR, char_code: c});
  endtask

  task automatic push_cmd(input logic [1:0] code);
    text_stream.push_back(rlsc_pkg::in_t'{cmd: code, char_code: 8'($urandom_range(0, 255))});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    push_cmd(rlsc_pkg::CMD_EOL);
  endtask

  // mostly well formed rule, at most one planted flaw
  task automatic push_rule_line();
    int flaw;
    flaw = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
    if (flaw != 1) repeat ($urandom_range(1, 3)) push_char(plain_char());
    if (flaw == 2) push_char(rlsc_pkg::CH_SPACE);
    if (flaw == 3) begin
      push_cmd(rlsc_pkg::CMD_EOL);
      return;
    end
    push_char(rlsc_pkg::CH_COMMA);
    if (flaw != 4) begin
      repeat ((flaw == 6) ? $urandom_range(2, 3) : $urandom_range(0, 1))
        push_char(plain_char());
      if (flaw == 5) begin
        case ($urandom_range(0, 2))
          0: ;
          1: begin
            push_char(rlsc_pkg::CH_DASH);
            push_char(plain_char());
          end
          default: push_char(rlsc_pkg::CH_DASH);
        endcase
      end else begin
        push_char(rlsc_pkg::CH_DASH);
        push_char(rlsc_pkg::CH_GT);
      end
      repeat ((flaw == 7) ? $urandom_range(2, 3) : $urandom_range(0, 1))
        push_char(plain_char());
    end
    if (flaw == 8) begin
      push_cmd(rlsc_pkg::CMD_EOL);
      return;
    end
    push_char(rlsc_pkg::CH_COMMA);
    if (flaw == 9) begin
      if ($urandom_range(0, 1)) begin
        push_char(pick_dir());
        push_char(pick_dir());
      end else begin
        push_char(plain_char());
      end
    end else if ($urandom_range(0, 3) != 0) begin
      push_char(pick_dir());
    end
    if (flaw == 10) begin
      push_cmd(rlsc_pkg::CMD_EOL);
      return;
    end
    push_char(rlsc_pkg::CH_COMMA);
    repeat ($urandom_range(0, 3)) push_char(plain_char());
    if (flaw == 11) begin
      push_char($urandom_range(0, 1) ? rlsc_pkg::CH_SPACE : rlsc_pkg::CH_COMMA);
      repeat ($urandom_range(0, 2)) push_char(plain_char());
    end
    push_cmd(rlsc_pkg::CMD_EOL);
  endtask

  // punctuation-heavy junk, with the odd unused command or new file mid-line
  task automatic push_noise_line();
    logic [7:0] c;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 9))
        0: c = rlsc_pkg::CH_COMMA;
        1: c = rlsc_pkg::CH_SPACE;
        2: c = rlsc_pkg::CH_DASH;
        3: c = rlsc_pkg::CH_GT;
        4: c = rlsc_pkg::CH_L;
        5: c = rlsc_pkg::CH_R;
        6: c = rlsc_pkg::CH_N;
        default: c = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 19) == 0) push_cmd(CMD_UNUSED);
      if ($urandom_range(0, 39) == 0) push_cmd(rlsc_pkg::CMD_NEW_FILE);
      push_char(c);
    end
    push_cmd(rlsc_pkg::CMD_EOL);
  endtask

  function int sender_idle_pct();
    if (taken < bound1) return 21;
    if (taken < bound2) return 65;
    return 0;
  endfunction

  function int receiver_stall_pct();
    if (taken < bound1) return 65;
    if (taken < bound2) return 21;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_command(in_data);
        taken <= taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (text_stream.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          in_data  <= text_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result: error_code %0d line_number %0d",
                 out_data.error_code, out_data.line_number);
          mismatches++;
        end else begin
          oldest_report = awaited_reports.pop_front();
          if (out_data.error_code !== oldest_report.error_code) begin
            $error("error_code: expected %0d, got %0d",
                   oldest_report.error_code, out_data.error_code);
            mismatches++;
          end
          if (out_data.line_number !== oldest_report.line_number) begin
            $error("line_number: expected %0d, got %0d",
                   oldest_report.line_number, out_data.line_number);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  initial begin
    int r;
    int start;
    reset_line();
    line_no = '0;

    push_line("q0,a->b,R,q1");
    push_cmd(rlsc_pkg::CMD_EOL);
    push_line(",a->b,R,q");
    push_line("q 0,a->b,R,q");
    push_line("q0");
    push_line("q0,");
    push_line("q0,,R,q");
    push_line("q0,ab,R,q");
    push_line("q0,a-,R,q");
    push_line("q0,a-x,R,q");
    push_line("q0,a->,R,q");
    push_line("q0,ab->c,R,q");
    push_line("q0,a->bc,R,q");
    push_line("q0,->,L,q");
    push_line("q0,a->b");
    push_line("q0,a->b,");
    push_line("q0,a->b,X,q");
    push_line("q0,a->b,LR,q");
    push_line("q0,a->b,L");
    push_line("q0,a->b,N,q 1");
    push_line("q0,a->b,N,q,1");
    // empty direction, then empty next state
    push_line("q0,a->b,,q");
    push_line("q0,a->b,L,");
    // zero and all-ones bytes are plain characters
    push_char(8'h00);
    push_text(",a->");
    push_char(8'hFF);
    push_text(",N,");
    push_char(8'h00);
    push_cmd(rlsc_pkg::CMD_EOL);
    push_text("s,");
    push_cmd(CMD_UNUSED);
    push_line("x->y,R,t");
    // new file drops the partial line and restarts numbering
    push_text("q0,a-");
    push_cmd(rlsc_pkg::CMD_NEW_FILE);
    push_line("s,x->y,L,t");
    repeat (320) push_char(plain_char());
    push_line(",a->b,R,q");

    start = text_stream.size();
    while (text_stream.size() < start + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) push_rule_line();
      else if (r < 85) push_noise_line();
      else if (r < 92) push_cmd(rlsc_pkg::CMD_EOL);
      else if (r < 96) push_cmd(rlsc_pkg::CMD_NEW_FILE);
      else push_cmd(CMD_UNUSED);
    end
    bound1 = text_stream.size() / 3;
    bound2 = 2 * text_stream.size() / 3;
    total_items = text_stream.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (taken != total_items) @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("rule_line_syntax_checker_unit_tb: clean");
    end else begin
      $display("rule_line_syntax_checker_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rule_line_syntax_checker_unit_tb: errors");
    $finish;
  end

endmodule
